>>> rtl/core/annexb_access_unit_splitter_macros.svh
// Assertion macros shared by the access unit splitter RTL.
`ifndef ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define AUS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("access unit splitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("access unit splitter: next-cycle check failed");

`else

`define AUS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AUS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/aus_pkg.sv
package aus_pkg;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 22;
    localparam int NAL_TYPE_W = 5;

    localparam int MAX_UNIT_BYTES_DEF    = 2097152;
    localparam int MAX_PENDING_BYTES_DEF = 65536;
    localparam int DELAY_DEPTH_DEF       = 6;

    // The line holds three more entries than the nominal delay depth.
    localparam int LINE_EXTRA_SLOTS = 3;
    // A byte leaves the line only while a later byte stays behind it.
    localparam int EMIT_MIN_FILL = 2;

    localparam int PUSH_CNT_W = 4;
    localparam int CODE_LEN_W = 3;

    localparam logic [DATA_W-1:0]     ZERO_BYTE       = 8'h00;
    localparam logic [DATA_W-1:0]     START_CODE_BYTE = 8'h01;
    localparam logic [1:0]            ZERO_RUN_MAX    = 2'd3;
    localparam logic [1:0]            START_ZERO_MIN  = 2'd2;
    localparam logic [CODE_LEN_W-1:0] CODE_LEN_NONE   = 3'd0;
    localparam logic [CODE_LEN_W-1:0] CODE_LEN_SHORT  = 3'd3;
    localparam logic [CODE_LEN_W-1:0] CODE_LEN_LONG   = 3'd4;
    localparam logic [NAL_TYPE_W-1:0] SLICE_TYPE_LOW  = 5'd1;
    localparam logic [NAL_TYPE_W-1:0] SLICE_TYPE_KEY  = 5'd5;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              unit_start;
        logic              unit_end;
        logic              unit_key;
        logic              pend;
    } line_entry_t;

    typedef struct packed {
        logic [PUSH_CNT_W-1:0] count;
        logic [CODE_LEN_W-1:0] code_len;
        logic [DATA_W-1:0]     data;
        logic                  start;
        logic                  pend;
        logic                  mark_end;
        logic                  mark_key;
    } push_plan_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              unit_start;
        logic              unit_end;
        logic              unit_key;
        logic [LEN_W-1:0]  unit_length;
        logic              unit_overflow;
    } result_t;

endpackage

>>> rtl/core/aus_parse.sv
module aus_parse import aus_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [DATA_W-1:0] data_byte,
    output push_plan_t        plan
);

    logic [1:0] zero_run_reg, zero_run_next;
    logic       seen_first_reg, seen_first_next;
    logic       expect_hdr_reg, expect_hdr_next;
    logic       open_long_reg, open_long_next;
    logic       have_slice_reg, have_slice_next;
    logic       key_seen_reg, key_seen_next;
    logic       next_start_reg, next_start_next;

    logic                  is_zero;
    logic                  start_hit;
    logic                  commit;
    logic                  hdr;
    logic                  is_slice;
    logic                  new_unit;
    logic                  start_flag;
    logic [CODE_LEN_W-1:0] code_len;
    logic [PUSH_CNT_W-1:0] body_cnt;
    logic [DATA_W-1:0]     hdr_byte;
    logic [NAL_TYPE_W-1:0] nal_type;

    always_comb begin
        is_zero   = (data_byte == ZERO_BYTE);
        start_hit = (data_byte == START_CODE_BYTE) && (zero_run_reg >= START_ZERO_MIN);
        commit    = seen_first_reg && (is_zero ? (zero_run_reg == ZERO_RUN_MAX) : !start_hit);
        body_cnt  = is_zero ? PUSH_CNT_W'(1) : PUSH_CNT_W'(zero_run_reg) + PUSH_CNT_W'(1);
        hdr       = commit && expect_hdr_reg;
        code_len  = hdr ? (open_long_reg ? CODE_LEN_LONG : CODE_LEN_SHORT) : CODE_LEN_NONE;

        // The header is the first body byte, which is a held zero when any are pending.
        hdr_byte  = (zero_run_reg == 2'd0) ? data_byte : ZERO_BYTE;
        nal_type  = hdr_byte[NAL_TYPE_W-1:0];
        is_slice  = hdr && (nal_type >= SLICE_TYPE_LOW) && (nal_type <= SLICE_TYPE_KEY);
        new_unit  = is_slice && have_slice_reg;

        have_slice_next = have_slice_reg | is_slice;
        key_seen_next   = is_slice ? (nal_type == SLICE_TYPE_KEY) : key_seen_reg;
        start_flag      = new_unit | next_start_reg;
        next_start_next = commit ? 1'b0 : start_flag;

        zero_run_next   = is_zero ? ((zero_run_reg == ZERO_RUN_MAX) ? ZERO_RUN_MAX
                                                                    : zero_run_reg + 2'd1)
                                  : 2'd0;
        expect_hdr_next = start_hit ? 1'b1 : (commit ? 1'b0 : expect_hdr_reg);
        open_long_next  = start_hit ? (zero_run_reg == ZERO_RUN_MAX) : open_long_reg;
        seen_first_next = seen_first_reg | start_hit;

        plan.count    = commit ? PUSH_CNT_W'(code_len) + body_cnt : PUSH_CNT_W'(0);
        plan.code_len = code_len;
        plan.data     = data_byte;
        plan.start    = start_flag;
        plan.pend     = !have_slice_next;
        plan.mark_end = new_unit;
        plan.mark_key = key_seen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg   <= 2'd0;
            seen_first_reg <= 1'b0;
            expect_hdr_reg <= 1'b0;
            open_long_reg  <= 1'b0;
            have_slice_reg <= 1'b0;
            key_seen_reg   <= 1'b0;
            next_start_reg <= 1'b1;
        end else if (step_en) begin
            zero_run_reg   <= zero_run_next;
            seen_first_reg <= seen_first_next;
            expect_hdr_reg <= expect_hdr_next;
            open_long_reg  <= open_long_next;
            have_slice_reg <= have_slice_next;
            key_seen_reg   <= key_seen_next;
            next_start_reg <= next_start_next;
        end
    end

endmodule

>>> rtl/core/aus_line.sv
module aus_line import aus_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  push_plan_t  plan,
    output logic        emit,
    output line_entry_t emit_entry
);

    localparam int SLOTS  = DELAY_DEPTH + LINE_EXTRA_SLOTS;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam logic [FILL_W:0] SLOTS_W    = (FILL_W+1)'(SLOTS);
    localparam logic [FILL_W:0] EMIT_MIN_W = (FILL_W+1)'(EMIT_MIN_FILL);

    line_entry_t line_reg  [SLOTS];
    line_entry_t line_next [SLOTS];
    line_entry_t pre       [SLOTS+1];

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W:0]   fill_ext;
    logic [FILL_W:0]   fill_sum;
    logic [FILL_W:0]   fill_pre;
    logic [FILL_W:0]   fill_post;
    logic [FILL_W:0]   pos;
    logic [FILL_W:0]   cnt_ext;
    logic [FILL_W:0]   code_ext;

    always_comb begin
        fill_ext = {1'b0, fill_reg};
        cnt_ext  = (FILL_W+1)'(plan.count);
        code_ext = (FILL_W+1)'(plan.code_len);
        fill_sum = fill_ext + cnt_ext;
        fill_pre = (fill_sum > SLOTS_W) ? SLOTS_W : fill_sum;
        emit     = (fill_pre >= EMIT_MIN_W);
        pos      = '0;

        // Held entries first, then this item's start code and body bytes.
        for (int j = 0; j <= SLOTS; j++) begin
            pre[j] = '0;
        end
        for (int j = 0; j < SLOTS; j++) begin
            pos = (FILL_W+1)'(j) - fill_ext;
            if ((FILL_W+1)'(j) < fill_ext) begin
                pre[j] = line_reg[j];
                if (plan.mark_end && ((FILL_W+1)'(j + 1) == fill_ext)) begin
                    pre[j].unit_end = 1'b1;
                    pre[j].unit_key = plan.mark_key;
                end
            end else if (pos < cnt_ext) begin
                if (pos < code_ext) begin
                    pre[j].data = (pos == code_ext - (FILL_W+1)'(1)) ? START_CODE_BYTE
                                                                     : ZERO_BYTE;
                end else begin
                    pre[j].data = (pos == cnt_ext - (FILL_W+1)'(1)) ? plan.data : ZERO_BYTE;
                end
                pre[j].unit_start = plan.start && (pos == '0);
                pre[j].pend       = plan.pend;
            end
        end

        for (int j = 0; j < SLOTS; j++) begin
            line_next[j] = emit ? pre[j+1] : pre[j];
        end

        fill_post  = emit ? fill_pre - (FILL_W+1)'(1) : fill_pre;
        fill_next  = fill_post[FILL_W-1:0];
        emit_entry = pre[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (step_en) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            line_reg <= line_next;
        end
    end

endmodule

>>> rtl/core/aus_count.sv
module aus_count import aus_pkg::*; #(
    parameter int MAX_UNIT_BYTES    = MAX_UNIT_BYTES_DEF,
    parameter int MAX_PENDING_BYTES = MAX_PENDING_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic        emit,
    input  line_entry_t entry,
    output result_t     result
);

    localparam int UNIT_W = $clog2(MAX_UNIT_BYTES + 1);
    localparam int PEND_W = $clog2(MAX_PENDING_BYTES + 1);
    localparam logic [UNIT_W-1:0] UNIT_LIMIT = UNIT_W'(MAX_UNIT_BYTES);
    localparam logic [PEND_W-1:0] PEND_LIMIT = PEND_W'(MAX_PENDING_BYTES);

    logic [UNIT_W-1:0] unit_reg, unit_next, unit_base;
    logic [PEND_W-1:0] pend_reg, pend_next, pend_base;
    logic              ovf_reg, ovf_next;
    logic [UNIT_W+LEN_W-1:0] unit_wide;

    always_comb begin
        unit_base = entry.unit_start ? '0 : unit_reg;
        pend_base = entry.unit_start ? '0 : pend_reg;
        ovf_next  = entry.unit_start ? 1'b0 : ovf_reg;

        if (unit_base < UNIT_LIMIT) begin
            unit_next = unit_base + UNIT_W'(1);
        end else begin
            unit_next = unit_base;
            ovf_next  = 1'b1;
        end

        pend_next = pend_base;
        if (entry.pend) begin
            if (pend_base < PEND_LIMIT) begin
                pend_next = pend_base + PEND_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        unit_wide = {{LEN_W{1'b0}}, unit_next};

        result.out_byte      = entry.data;
        result.unit_start    = entry.unit_start;
        result.unit_end      = entry.unit_end;
        result.unit_key      = entry.unit_end & entry.unit_key;
        result.unit_length   = entry.unit_end ? unit_wide[LEN_W-1:0] : '0;
        result.unit_overflow = entry.unit_end & ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= '0;
            pend_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (step_en && emit) begin
            unit_reg <= unit_next;
            pend_reg <= pend_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

>>> rtl/core/annexb_access_unit_splitter.sv
// Splits an H.264 Annex-B byte stream into access units, one byte per item.
// The input channel (s_valid, s_ready, s_data_byte) takes one stream byte per
// cycle. The output channel (m_valid, m_ready, m_*) gives the kept bytes in
// order, each tagged with unit_start, and the last byte of each access unit
// also with unit_end, unit_key, unit_length and unit_overflow.
// An accepted byte is held in an input register, and its effect is then
// registered in the output register, where the result that it releases
// shows up. Because kept bytes pass through a short delay line, an output
// byte usually belongs to an earlier input. While the output is taken,
// throughput is one input byte per cycle, with at most one output per input.
// Bytes ahead of the first start code, and the start codes of empty NAL units,
// produce no output; there is no end-of-stream flush.
// After reset all scanner state, counters and the delay line are empty, and
// the block is ready at once. When the receiver stalls, the pending result
// holds in the output register and one more byte waits in the input register;
// s_ready then drops until the output is taken.
`include "annexb_access_unit_splitter_macros.svh"

module annexb_access_unit_splitter import aus_pkg::*; #(
    parameter int MAX_UNIT_BYTES    = MAX_UNIT_BYTES_DEF,
    parameter int MAX_PENDING_BYTES = MAX_PENDING_BYTES_DEF,
    parameter int DELAY_DEPTH       = DELAY_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_out_byte,
    output logic              m_unit_start,
    output logic              m_unit_end,
    output logic              m_unit_key,
    output logic [LEN_W-1:0]  m_unit_length,
    output logic              m_unit_overflow
);

    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic        out_free;
    logic        proc_en;
    logic        line_emit;
    push_plan_t  plan;
    line_entry_t emit_entry;
    result_t     step_res;

    assign out_free = !out_valid_reg || m_ready;
    assign proc_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    aus_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (proc_en),
        .data_byte (in_byte_reg),
        .plan      (plan)
    );

    aus_line #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (proc_en),
        .plan       (plan),
        .emit       (line_emit),
        .emit_entry (emit_entry)
    );

    aus_count #(
        .MAX_UNIT_BYTES    (MAX_UNIT_BYTES),
        .MAX_PENDING_BYTES (MAX_PENDING_BYTES)
    ) u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (proc_en),
        .emit    (line_emit),
        .entry   (emit_entry),
        .result  (step_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_en) begin
            out_valid_next = line_emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (proc_en && line_emit) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_res_reg.out_byte;
    assign m_unit_start    = out_res_reg.unit_start;
    assign m_unit_end      = out_res_reg.unit_end;
    assign m_unit_key      = out_res_reg.unit_key;
    assign m_unit_length   = out_res_reg.unit_length;
    assign m_unit_overflow = out_res_reg.unit_overflow;

    `AUS_ASSERT_IMPLY(a_ready_when_out_empty, aclk, aresetn, !m_valid, s_ready)
    `AUS_ASSERT_NEXT(a_emit_reaches_output, aclk, aresetn, proc_en && line_emit, m_valid)
    `AUS_ASSERT_IMPLY(a_single_byte_unit, aclk, aresetn, m_valid && m_unit_start && m_unit_end, m_unit_length == LEN_W'(1))
    `AUS_ASSERT_IMPLY(a_tags_only_at_end, aclk, aresetn, m_valid && !m_unit_end, !m_unit_key && !m_unit_overflow && (m_unit_length == '0))

endmodule
